>>> hw/rtl/gac_pkg.sv
`default_nettype none

package gac_pkg;

	localparam int MAX_NODES = 32;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = NODE_W + 1;
	localparam int CFG_W     = 6;
	localparam int MASK_W    = 32;

	localparam logic ACT_EDGE   = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	typedef logic [MAX_NODES-1:0] row_t;
	typedef logic [NODE_W-1:0]    node_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_COPY  = 6'b000010,
		ST_CL_RD = 6'b000100,
		ST_CL_WR = 6'b001000,
		ST_EM_RD = 6'b010000,
		ST_EM_WR = 6'b100000
	} state_t;

endpackage

`default_nettype wire

>>> hw/rtl/gac_ram.sv
`default_nettype none

module gac_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_a_q <= mem_q[raddr_a];
		rd_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

`default_nettype wire

>>> hw/rtl/graph_ancestor_closure.sv
// Transitive closure of a directed graph of up to 32 nodes. Each edge item (action 0) is
// taken while idle and sets one bit of a flip-flop parent matrix; edges touching a node
// at or above node_count are dropped. A finish item (action 1) keeps busy high while,
// n being node_count capped at 32, the n parent rows are copied into the ancestor RAM,
// then a Warshall pass runs each (k, i) row step as a read state and a write state on
// one shared row-OR unit that reads two RAM rows and writes one back, then the n results
// come out in node order, each after a read state, last_node flagging the final one. Each
// result is held for one cycle under result_strobe and cannot be stalled by the receiver.
// The parent matrix is cleared when the copy completes, or right away when n is zero, in
// which case a finish emits nothing and busy does not rise.
`default_nettype none

module graph_ancestor_closure
	import gac_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              action,
	input  wire logic [4:0]        from_node,
	input  wire logic [4:0]        to_node,
	output logic                   result_strobe,
	output logic [4:0]             node_index,
	output logic [MASK_W-1:0]      ancestor_mask,
	output logic                   last_node
);

	state_t            state_q;
	logic [CFG_W-1:0]  node_count_q;
	row_t              parent_q [MAX_NODES];
	node_t             i_q;
	node_t             k_q;

	logic [CNT_W-1:0]  eff_n;
	node_t             last_idx;
	row_t              use_mask;
	logic              accept;
	logic              edge_ok;
	logic              i_last;
	logic              k_last;
	logic              ram_we;
	row_t              ram_wdata;
	row_t              row_k;
	row_t              row_i;

	assign eff_n    = (node_count_q > CFG_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
	                                                     : CNT_W'(node_count_q);
	assign last_idx = NODE_W'(eff_n - CNT_W'(1));
	assign i_last   = (i_q == last_idx);
	assign k_last   = (k_q == last_idx);

	always_comb begin
		for (int j = 0; j < MAX_NODES; j++) begin
			use_mask[j] = (CNT_W'(j) < eff_n);
		end
	end

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign edge_ok = ({1'b0, from_node} < eff_n) && ({1'b0, to_node} < eff_n);

	// shared row unit: copy during load, or-in row k when bit k of row i is set
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = row_i | row_k;
		if (state_q == ST_COPY) begin
			ram_we    = 1'b1;
			ram_wdata = parent_q[i_q] & use_mask;
		end else if (state_q == ST_CL_WR) begin
			ram_we = row_i[k_q];
		end
	end

	gac_ram #(
		.WIDTH (MAX_NODES),
		.DEPTH (MAX_NODES)
	) u_anc_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (i_q),
		.wdata   (ram_wdata),
		.raddr_a (k_q),
		.rdata_a (row_k),
		.raddr_b (i_q),
		.rdata_b (row_i)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CFG_W'(MAX_NODES);
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			k_q     <= '0;
			for (int r = 0; r < MAX_NODES; r++) begin
				parent_q[r] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (action == ACT_EDGE) begin
							if (edge_ok) begin
								parent_q[to_node][from_node] <= 1'b1;
							end
						end else if (eff_n == '0) begin
							for (int r = 0; r < MAX_NODES; r++) begin
								parent_q[r] <= '0;
							end
						end else begin
							i_q     <= '0;
							state_q <= ST_COPY;
						end
					end
				end
				ST_COPY: begin
					if (i_last) begin
						for (int r = 0; r < MAX_NODES; r++) begin
							parent_q[r] <= '0;
						end
						i_q     <= '0;
						k_q     <= '0;
						state_q <= ST_CL_RD;
					end else begin
						i_q <= i_q + NODE_W'(1);
					end
				end
				ST_CL_RD: begin
					state_q <= ST_CL_WR;
				end
				ST_CL_WR: begin
					if (i_last) begin
						i_q <= '0;
						if (k_last) begin
							state_q <= ST_EM_RD;
						end else begin
							k_q     <= k_q + NODE_W'(1);
							state_q <= ST_CL_RD;
						end
					end else begin
						i_q     <= i_q + NODE_W'(1);
						state_q <= ST_CL_RD;
					end
				end
				ST_EM_RD: begin
					state_q <= ST_EM_WR;
				end
				ST_EM_WR: begin
					if (i_last) begin
						state_q <= ST_IDLE;
					end else begin
						i_q     <= i_q + NODE_W'(1);
						state_q <= ST_EM_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_strobe = (state_q == ST_EM_WR);
	assign node_index    = i_q;
	assign ancestor_mask = MASK_W'(row_i);
	assign last_node     = i_last;

endmodule

`default_nettype wire

>>> hw/rtl/gac_chk.sv
`default_nettype none

module gac_chk
	import gac_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire logic             action,
	input wire logic             result_strobe,
	input wire logic [4:0]       node_index,
	input wire logic             last_node
);

	// results only come out of a finish run
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy)
		else $error("result outside a finish run");

	// an edge transfer never starts a run
	a_edge_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_EDGE) |=> !busy)
		else $error("edge transfer raised busy");

	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe)
		else $error("back to back results");

	// results step through the nodes in order
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last_node) |=> ##1
			(result_strobe && node_index == 5'($past(node_index, 2) + 5'd1)))
		else $error("result order broken");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last_node) |=> !busy)
		else $error("busy after last result");

endmodule

bind graph_ancestor_closure gac_chk u_gac_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.action        (action),
	.result_strobe (result_strobe),
	.node_index    (node_index),
	.last_node     (last_node)
);

`default_nettype wire
